>>> rtl/bds_pkg.sv
// Shared types, constants and the sequencer control store of the battery discharge simulator.
`default_nettype none

package bds_pkg;

  // Block dimensions
  localparam int NUM_BATT  = 4;
  localparam int BATT_W    = 2;
  localparam int FRAC_BITS = 24;
  localparam int FRAC_W    = FRAC_BITS + 1;
  localparam int TIME_W    = 48;
  localparam int DRAIN_W   = 16;
  localparam int PCT_W     = 7;
  localparam int MV_W      = 13;
  localparam int CELLS_W   = 5;
  localparam int VOLT_W    = 17;
  localparam int US_W      = 20;
  localparam int DEN_W     = DRAIN_W + US_W;
  localparam int ACC_W     = 45;
  localparam int MULB_W    = 39;
  localparam int PROD_W    = MV_W + MULB_W;

  localparam logic [FRAC_W-1:0]  FULL_CHARGE = FRAC_W'(1) << FRAC_BITS;
  localparam logic [US_W-1:0]    US_PER_S    = US_W'(1000000);
  localparam logic [PCT_W-1:0]   PCT_MAX     = PCT_W'(100);
  localparam logic [ACC_W-1:0]   ROUND_HALF  = ACC_W'(1) << (FRAC_BITS - 1);
  localparam logic [VOLT_W-1:0]  VOLT_MAX    = '1;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEFAULT_DRAIN = 3'd0,
    REG_DEFAULT_PCT   = 3'd1,
    REG_DRAIN_OVR     = 3'd2,
    REG_FLOOR_OVR     = 3'd3,
    REG_EMPTY_MV      = 3'd4,
    REG_FULL_MV       = 3'd5,
    REG_CELLS         = 3'd6
  } cfg_reg_t;

  // Transaction payloads
  typedef struct packed {
    logic [TIME_W-1:0] now_us;
    logic              armed;
  } in_item_t;

  typedef struct packed {
    logic [BATT_W-1:0] battery_no;
    logic [VOLT_W-1:0] pack_voltage_mv;
    logic [FRAC_W-1:0] charge_fraction;
    logic              last_of_tick;
  } out_item_t;

  // Divider control
  typedef struct packed {
    logic load;
    logic step;
  } div_ctrl_t;

  // Sequencer control word
  localparam int UPC_W = 4;
  typedef logic [UPC_W-1:0] upc_t;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_LOAD,
    OP_DIV_TIME,
    OP_DIV_STEP,
    OP_APPLY,
    OP_CLAMP,
    OP_MUL_EMPTY,
    OP_MUL_FULL,
    OP_MUL_CELLS,
    OP_EMIT,
    OP_ADVANCE
  } op_t;

  typedef enum logic [2:0] {
    J_NEXT,
    J_GOTO,
    J_WAIT_IN,
    J_DIV,
    J_EMIT
  } jmp_t;

  typedef struct packed {
    op_t  op;
    jmp_t jmp;
    upc_t target;
  } uop_t;

  localparam upc_t U_IDLE = 4'd0;
  localparam upc_t U_LOAD = 4'd1;

  // Control store: one battery per pass from U_LOAD to the advance step
  function automatic uop_t ucode(input upc_t pc);
    uop_t w;
    unique case (pc)
      4'd0:    w = '{op: OP_IDLE,      jmp: J_WAIT_IN, target: U_IDLE};
      4'd1:    w = '{op: OP_LOAD,      jmp: J_NEXT,    target: U_IDLE};
      4'd2:    w = '{op: OP_DIV_TIME,  jmp: J_NEXT,    target: U_IDLE};
      4'd3:    w = '{op: OP_DIV_STEP,  jmp: J_DIV,     target: U_IDLE};
      4'd4:    w = '{op: OP_APPLY,     jmp: J_NEXT,    target: U_IDLE};
      4'd5:    w = '{op: OP_CLAMP,     jmp: J_NEXT,    target: U_IDLE};
      4'd6:    w = '{op: OP_MUL_EMPTY, jmp: J_NEXT,    target: U_IDLE};
      4'd7:    w = '{op: OP_MUL_FULL,  jmp: J_NEXT,    target: U_IDLE};
      4'd8:    w = '{op: OP_MUL_CELLS, jmp: J_NEXT,    target: U_IDLE};
      4'd9:    w = '{op: OP_EMIT,      jmp: J_EMIT,    target: U_IDLE};
      4'd10:   w = '{op: OP_ADVANCE,   jmp: J_GOTO,    target: U_LOAD};
      default: w = '{op: OP_IDLE,      jmp: J_GOTO,    target: U_IDLE};
    endcase
    return w;
  endfunction

  // Charge floor for a whole percent, floor(pct * full / 100), as a constant table
  function automatic logic [FRAC_W-1:0] pct_floor(input logic [PCT_W-1:0] p);
    logic [FRAC_W-1:0] f;
    f = '0;
    for (int k = 0; k <= int'(PCT_MAX); k++) begin
      if (p == PCT_W'(k)) begin
        f = FRAC_W'((64'(k) << FRAC_BITS) / 64'(PCT_MAX));
      end
    end
    return f;
  endfunction

endpackage

`default_nettype wire

>>> rtl/bds_div.sv
// Restoring divider: one quotient bit per cycle, saturating at full charge.
`default_nettype none

module bds_div
  import bds_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire div_ctrl_t         ctrl,
  input  wire logic [TIME_W-1:0] num,
  input  wire logic [DEN_W-1:0]  den,
  output logic [FRAC_W-1:0]      quo,
  output logic                   last_step
);

  localparam int CNT_W = $clog2(FRAC_BITS);

  logic [DEN_W-1:0]     rem;
  logic [FRAC_BITS-1:0] qbits;
  logic                 sat;
  logic [CNT_W-1:0]     cnt;
  logic [DEN_W:0]       rem2;
  logic                 ge;

  // Trial subtract of the shifted remainder
  always_comb begin
    rem2 = {rem, 1'b0};
    ge   = (rem2 >= {1'b0, den});
  end

  // Step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (ctrl.load) begin
      cnt <= '0;
    end else if (ctrl.step) begin
      cnt <= cnt + CNT_W'(1);
    end
  end

  // Remainder and quotient
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      sat   <= (num >= {{(TIME_W-DEN_W){1'b0}}, den});
      rem   <= num[DEN_W-1:0];
      qbits <= '0;
    end else if (ctrl.step) begin
      if (ge) begin
        rem <= DEN_W'(rem2 - {1'b0, den});
      end else begin
        rem <= rem2[DEN_W-1:0];
      end
      qbits <= {qbits[FRAC_BITS-2:0], ge};
    end
  end

  assign last_step = (cnt == CNT_W'(FRAC_BITS - 1));
  assign quo       = sat ? FULL_CHARGE : {1'b0, qbits};

endmodule

`default_nettype wire

>>> rtl/battery_discharge_simulator_core.sv
// Battery discharge simulator: control-store sequencer driving a divide and multiply datapath.
//
// Usage:
//   in_valid/in_stall/in_data carry one timer tick (now_us, armed). A tick is
//   taken only while the sequencer sits in its idle step; in_stall is high
//   for the whole time a tick is being worked on.
//   out_valid/out_stall/out_data return one result per battery, batteries
//   0..3 in order, last_of_tick set on battery 3.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write one configuration register;
//   cfg_ready is always high. Write only while the block is idle.
// Sequence:
//   Each battery runs two load steps, a divide for the discharge, apply, a
//   clamp against the floor read from a constant percent table, three
//   multiply steps, emit and advance, all on one sequencer. The last battery
//   skips the advance step and returns to the idle step once its result is
//   emitted; only then can the next tick be accepted.
// Reset and stall:
//   rst (synchronous) restores register defaults, full charge on every
//   battery and no prior tick. A stalled result holds in the output register;
//   the sequencer waits at its emit step until the register frees up.
`default_nettype none

module battery_discharge_simulator_core
  import bds_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire in_item_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_item_t                  out_data,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  // Configuration registers
  logic [DRAIN_W-1:0]          default_drain_s;
  logic [PCT_W-1:0]            default_min_pct;
  logic [NUM_BATT*DRAIN_W-1:0] drain_override_table;
  logic [NUM_BATT*8-1:0]       floor_override_table;
  logic [MV_W-1:0]             empty_cell_mv;
  logic [MV_W-1:0]             full_cell_mv;
  logic [CELLS_W-1:0]          cells_in_pack;

  // Sequencer and state
  upc_t               pc;
  upc_t               pc_next;
  uop_t               uop;
  logic [BATT_W-1:0]  batt;
  logic [TIME_W-1:0]  last_tick_us;
  logic [FRAC_W-1:0]  charge_store [NUM_BATT];

  // Datapath registers
  logic [TIME_W-1:0]  elapsed;
  logic               discharging;
  logic               armed_q;
  logic [DEN_W-1:0]   denom;
  logic [FRAC_W-1:0]  floor_q;
  logic [FRAC_W-1:0]  q;
  logic [ACC_W-1:0]   acc;

  // Combinational datapath
  logic               in_fire;
  logic               out_free;
  logic               emit_fire;
  logic               last_batt;
  logic [DRAIN_W-1:0] drain_ovr;
  logic [DRAIN_W-1:0] drain_sel;
  logic [7:0]         floor_byte;
  logic [7:0]         pct_raw;
  logic [PCT_W-1:0]   pct_sel;
  div_ctrl_t          div_ctrl;
  logic [FRAC_W-1:0]  div_quo;
  logic               div_last;
  logic [FRAC_W-1:0]  q_clamped;
  logic [MV_W-1:0]    mul_a;
  logic [MULB_W-1:0]  mul_b;
  logic [PROD_W-1:0]  prod;
  logic [ACC_W-1:0]   acc_next;
  logic [ACC_W-FRAC_BITS-1:0] volt_raw;
  logic [VOLT_W-1:0]  volt_sat;

  assign uop       = ucode(pc);
  assign in_stall  = (uop.op != OP_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign emit_fire = (uop.op == OP_EMIT) && out_free;
  assign last_batt = (batt == BATT_W'(NUM_BATT - 1));
  assign cfg_ready = 1'b1;

  // Next step of the sequencer
  always_comb begin
    pc_next = pc;
    unique case (uop.jmp)
      J_NEXT:    pc_next = pc + UPC_W'(1);
      J_GOTO:    pc_next = uop.target;
      J_WAIT_IN: pc_next = in_fire ? pc + UPC_W'(1) : pc;
      J_DIV:     pc_next = div_last ? pc + UPC_W'(1) : pc;
      J_EMIT: begin
        if (!out_free) begin
          pc_next = pc;
        end else if (last_batt) begin
          pc_next = uop.target;
        end else begin
          pc_next = pc + UPC_W'(1);
        end
      end
      default:   pc_next = uop.target;
    endcase
  end

  // Pick drain time and floor percent for the current battery
  always_comb begin
    drain_ovr  = drain_override_table[DRAIN_W*batt +: DRAIN_W];
    drain_sel  = (drain_ovr != '0) ? drain_ovr : default_drain_s;
    if (drain_sel == '0) begin
      drain_sel = DRAIN_W'(1);
    end
    floor_byte = floor_override_table[8*batt +: 8];
    pct_raw    = floor_byte[7] ? {1'b0, default_min_pct} : floor_byte;
    pct_sel    = (pct_raw > {1'b0, PCT_MAX}) ? PCT_MAX : pct_raw[PCT_W-1:0];
  end

  // Divider control
  always_comb begin
    div_ctrl.load = (uop.op == OP_DIV_TIME);
    div_ctrl.step = (uop.op == OP_DIV_STEP);
  end

  bds_div u_div (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (div_ctrl),
    .num       (elapsed),
    .den       (denom),
    .quo       (div_quo),
    .last_step (div_last)
  );

  // Raise the charge to the floor, cap at full
  always_comb begin
    q_clamped = (q < floor_q) ? floor_q : q;
    if (q_clamped > FULL_CHARGE) begin
      q_clamped = FULL_CHARGE;
    end
  end

  // Shared multiplier for the voltage blend
  always_comb begin
    case (uop.op)
      OP_MUL_EMPTY: begin
        mul_a = empty_cell_mv;
        mul_b = MULB_W'(FULL_CHARGE - q);
      end
      OP_MUL_FULL: begin
        mul_a = full_cell_mv;
        mul_b = MULB_W'(q);
      end
      default: begin
        mul_a = MV_W'(cells_in_pack);
        mul_b = acc[MULB_W-1:0];
      end
    endcase
    prod = PROD_W'(mul_a) * PROD_W'(mul_b);
    case (uop.op)
      OP_MUL_EMPTY: acc_next = prod[ACC_W-1:0];
      OP_MUL_FULL:  acc_next = acc + prod[ACC_W-1:0];
      default:      acc_next = prod[ACC_W-1:0] + ROUND_HALF;
    endcase
  end

  // Round and saturate the pack voltage
  always_comb begin
    volt_raw = acc[ACC_W-1:FRAC_BITS];
    volt_sat = (volt_raw > (ACC_W-FRAC_BITS)'(VOLT_MAX)) ? VOLT_MAX : volt_raw[VOLT_W-1:0];
  end

  // Control state, configuration and per-battery charge
  always_ff @(posedge clk) begin
    if (rst) begin
      pc                   <= U_IDLE;
      batt                 <= '0;
      out_valid            <= 1'b0;
      last_tick_us         <= '0;
      default_drain_s      <= DRAIN_W'(60);
      default_min_pct      <= PCT_W'(50);
      drain_override_table <= '0;
      floor_override_table <= '1;
      empty_cell_mv        <= MV_W'(3600);
      full_cell_mv         <= MV_W'(4050);
      cells_in_pack        <= CELLS_W'(3);
      for (int i = 0; i < NUM_BATT; i++) begin
        charge_store[i] <= FULL_CHARGE;
      end
    end else begin
      pc <= pc_next;

      // Take a register write
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_DEFAULT_DRAIN: default_drain_s      <= cfg_data[DRAIN_W-1:0];
          REG_DEFAULT_PCT:   default_min_pct      <= cfg_data[PCT_W-1:0];
          REG_DRAIN_OVR:     drain_override_table <= cfg_data[NUM_BATT*DRAIN_W-1:0];
          REG_FLOOR_OVR:     floor_override_table <= cfg_data[NUM_BATT*8-1:0];
          REG_EMPTY_MV:      empty_cell_mv        <= cfg_data[MV_W-1:0];
          REG_FULL_MV:       full_cell_mv         <= cfg_data[MV_W-1:0];
          REG_CELLS:         cells_in_pack        <= cfg_data[CELLS_W-1:0];
          default:           ;
        endcase
      end

      // Start a tick: restart the battery count, note the tick time or clear it when not armed
      if (in_fire) begin
        batt         <= '0;
        last_tick_us <= in_data.armed ? in_data.now_us : '0;
      end

      if (uop.op == OP_ADVANCE) begin
        batt <= batt + BATT_W'(1);
      end

      if (uop.op == OP_CLAMP) begin
        charge_store[batt] <= q_clamped;
      end

      // Output register: drop on take, load on emit
      if (emit_fire) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      elapsed     <= in_data.now_us - last_tick_us;
      discharging <= in_data.armed && (last_tick_us != '0);
      armed_q     <= in_data.armed;
    end

    case (uop.op)
      OP_LOAD: begin
        q       <= charge_store[batt];
        denom   <= DEN_W'(drain_sel) * DEN_W'(US_PER_S);
        floor_q <= pct_floor(pct_sel);
      end
      OP_APPLY: begin
        if (!armed_q) begin
          q <= FULL_CHARGE;
        end else if (discharging) begin
          q <= (div_quo >= q) ? '0 : q - div_quo;
        end
      end
      OP_CLAMP: q <= q_clamped;
      OP_MUL_EMPTY, OP_MUL_FULL, OP_MUL_CELLS: acc <= acc_next;
      default: ;
    endcase

    if (emit_fire) begin
      out_data.battery_no      <= batt;
      out_data.pack_voltage_mv <= volt_sat;
      out_data.charge_fraction <= q;
      out_data.last_of_tick    <= last_batt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/bds_checker.sv
// Port-level assertions for the battery discharge simulator, bound to the top level.
`default_nettype none

module bds_checker
  import bds_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  input  wire logic                  in_stall,
  input  wire logic                  out_valid,
  input  wire logic                  out_stall,
  input  wire out_item_t             out_data
);

  // Leave reset idle and ready for a tick
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !in_stall && !out_valid)
    else $error("block not idle after reset");

  // A tick transaction occupies the block
  a_busy_after_tick: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("tick accepted without entering busy");

  // Last-of-tick marks exactly the final battery
  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.last_of_tick == (out_data.battery_no == BATT_W'(NUM_BATT - 1))))
    else $error("last_of_tick on wrong battery");

  // Charge never above full
  a_charge_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.charge_fraction <= FULL_CHARGE)
    else $error("charge fraction above full");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

endmodule

bind battery_discharge_simulator_core bds_checker u_bds_checker (.*);

`default_nettype wire
